/* hw/rtl/slc_pkg.sv */
// Shared types and constants for the sprite line cache and pixel lookup.
// No dependencies.
`timescale 1ns / 1ps
package slc_pkg;
    localparam int SPRITE_COUNT_DEF = 64;
    localparam int CHAR_COUNT_DEF   = 512;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ATTR_W     = 36;
    localparam int ROW_W      = 16;
    localparam int ENTRY_W    = 28;
    localparam int TDATA_W    = 58;
    localparam int RES_W      = 16;

    typedef enum logic [1:0] {
        OP_SPRITE = 2'd0,
        OP_ROW    = 2'd1,
        OP_CACHE  = 2'd2,
        OP_RENDER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_COLOR_MODEL = 3'd0,
        REG_COMPAT_MODE = 3'd1,
        REG_SCROLL_X    = 3'd2,
        REG_SCROLL_Y    = 3'd3,
        REG_COMPAT_BASE = 3'd4,
        REG_NATIVE_BASE = 3'd5,
        REG_MONO_PAL    = 3'd6
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic sprite_we;   // write attribute table
        logic row_we;      // write character rows
        logic cache_start; // reset chain/count for walk
        logic attr_rd;     // issue attribute read (index = walk counter)
        logic attr_use;    // attribute data valid: evaluate
        logic list_rd;     // issue list read
        logic list_use;    // list entry valid: issue char read
        logic row_use;     // char row valid: evaluate pixel
        logic walk_inc;    // advance walk counter
        logic result_load; // load output register
    } slc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       walk_last_attr; // counter at last sprite
        logic       walk_last_list; // counter at last list entry
        logic       list_empty;
        logic       hit;            // opaque pixel found
        logic       out_busy;       // output register full and not taken
    } slc_stat_t;
endpackage

/* hw/rtl/slc_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/slc_ctrl.sv */
// Sequencer for the sprite line cache: walks attribute table or line list.
// Depends on slc_pkg.
`timescale 1ns / 1ps
module slc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  slc_pkg::slc_stat_t stat,
    output slc_pkg::slc_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_ATTR, S_LIST, S_ROW, S_EVAL, S_DONE
    } state_t;

    state_t state_reg;
    logic   attr_wait_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.load = in_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_DISPATCH:
            begin
                case (slc_pkg::op_t'(stat.op))
                    slc_pkg::OP_SPRITE: cmd.sprite_we = 1'b1;
                    slc_pkg::OP_ROW:    cmd.row_we = 1'b1;
                    slc_pkg::OP_CACHE:
                    begin
                        cmd.cache_start = 1'b1;
                        cmd.attr_rd = 1'b1;
                    end
                    default:
                    begin
                        cmd.cache_start = 1'b1;
                        cmd.list_rd = 1'b1;
                    end
                endcase
            end
            S_ATTR:
            begin
                cmd.attr_use = attr_wait_reg;
                cmd.attr_rd = 1'b1;
                cmd.walk_inc = attr_wait_reg;
            end
            S_LIST: cmd.list_use = 1'b1;
            S_ROW:  cmd.row_use = 1'b1;
            S_EVAL:
            begin
                cmd.walk_inc = !stat.hit;
                cmd.list_rd = !stat.hit;
            end
            S_DONE: cmd.result_load = !stat.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            attr_wait_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    attr_wait_reg <= 1'b0;
                    case (slc_pkg::op_t'(stat.op))
                        slc_pkg::OP_CACHE:  state_reg <= S_ATTR;
                        slc_pkg::OP_RENDER:
                            state_reg <= stat.list_empty ? S_DONE : S_LIST;
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_ATTR:
                begin
                    attr_wait_reg <= 1'b1;
                    if (attr_wait_reg && stat.walk_last_attr)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_LIST: state_reg <= S_ROW;
                S_ROW:  state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (stat.hit || stat.walk_last_list)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LIST;
                    end
                end
                S_DONE:
                begin
                    if (!stat.out_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sprite_we && cmd.row_we)) else $error("double write");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DISPATCH) else $error("load lost");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && stat.out_busy) |=> state_reg == S_DONE)
        else $error("result dropped");
endmodule

/* hw/rtl/slc_dp.sv */
// Datapath: attribute table, character rows, line list, pixel evaluation.
// Depends on slc_pkg and slc_ram.
`timescale 1ns / 1ps
module slc_dp #(
    parameter int SPRITE_COUNT = slc_pkg::SPRITE_COUNT_DEF,
    parameter int CHAR_COUNT   = slc_pkg::CHAR_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slc_pkg::slc_cmd_t         cmd,
    output slc_pkg::slc_stat_t        stat,
    input  logic [slc_pkg::TDATA_W-1:0] in_data,
    input  logic                      cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [slc_pkg::RES_W-1:0] out_data
);
    localparam int SW  = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int CW  = $clog2(SPRITE_COUNT + 1);
    localparam int ROWS = CHAR_COUNT * 8;
    localparam int RW  = $clog2(ROWS);

    // config
    logic        color_reg, compat_reg;
    logic [7:0]  sx_cfg_reg, sy_cfg_reg;
    logic [8:0]  cbase_reg, nbase_reg;
    logic [23:0] mono_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= 1'b0; compat_reg <= 1'b0;
            sx_cfg_reg <= '0; sy_cfg_reg <= '0;
            cbase_reg <= '0; nbase_reg <= '0; mono_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (slc_pkg::reg_idx_t'(cfg_index))
                slc_pkg::REG_COLOR_MODEL: color_reg <= cfg_data[0];
                slc_pkg::REG_COMPAT_MODE: compat_reg <= cfg_data[0];
                slc_pkg::REG_SCROLL_X:    sx_cfg_reg <= cfg_data[7:0];
                slc_pkg::REG_SCROLL_Y:    sy_cfg_reg <= cfg_data[7:0];
                slc_pkg::REG_COMPAT_BASE: cbase_reg <= cfg_data[8:0];
                slc_pkg::REG_NATIVE_BASE: nbase_reg <= cfg_data[8:0];
                slc_pkg::REG_MONO_PAL:    mono_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item: op[1:0] target[13:2] data[49:14] pos[57:50] of in_data
    logic [1:0]  op_reg;
    logic [11:0] tgt_reg;
    logic [35:0] wd_reg;
    logic [7:0]  pos_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_data[1:0];
            tgt_reg <= in_data[13:2];
            wd_reg  <= in_data[49:14];
            pos_reg <= in_data[57:50];
        end
    end

    // walk counter and list count
    logic [CW-1:0] walk_reg, count_reg;
    logic [CW-1:0] walk_nx;
    logic [SW-1:0] rd_addr;
    logic [7:0]    px_reg, py_reg;

    // tables are read one step ahead: the cycle that advances the counter
    // already addresses the next entry
    assign walk_nx = walk_reg + 1'b1;
    always_comb
    begin
        if (cmd.cache_start)
            rd_addr = '0;
        else if (cmd.walk_inc && (cmd.attr_rd || cmd.list_rd))
            rd_addr = walk_nx[SW-1:0];
        else
            rd_addr = walk_reg[SW-1:0];
    end

    // attribute RAM
    logic [35:0] attr_q;
    logic        sprite_ok;
    assign sprite_ok = 32'(tgt_reg) < SPRITE_COUNT;
    slc_ram #(.WIDTH(slc_pkg::ATTR_W), .DEPTH(1 << SW)) u_attr (
        .clk(clk), .we(cmd.sprite_we && sprite_ok), .waddr(tgt_reg[SW-1:0]),
        .wdata(wd_reg), .raddr(rd_addr), .rdata(attr_q));

    // evaluate an attribute entry
    logic [7:0] sx, sy, ex, ey;
    logic       listed;
    logic [27:0] entry;
    always_comb
    begin
        sx = attr_q[7:0] + (attr_q[16] ? px_reg : 8'd0);
        sy = attr_q[15:8] + (attr_q[17] ? py_reg : 8'd0);
        ex = sx + sx_cfg_reg + 8'd7;
        ey = sy + sy_cfg_reg + 8'd7 - pos_reg;
        listed = (attr_q[19:18] != 2'd0) && (ey < 8'd8)
                 && (32'(count_reg) < SPRITE_COUNT);
        // x[7:0] row[10:8] chr[19:11] prio[21:20] pal[22] hflip[23] code[27:24]
        entry = {attr_q[35:32], attr_q[30], attr_q[29], attr_q[19:18],
                 attr_q[28:20], ey[2:0] ^ {3{~attr_q[31]}}, ex};
    end

    // line list RAM (written during walk; read indexed by walk counter)
    logic [27:0] list_q;
    logic [SW-1:0] list_waddr;
    assign list_waddr = count_reg[SW-1:0];
    slc_ram #(.WIDTH(slc_pkg::ENTRY_W), .DEPTH(1 << SW)) u_list (
        .clk(clk), .we(cmd.attr_use && listed), .waddr(list_waddr),
        .wdata(entry), .raddr(rd_addr), .rdata(list_q));

    // character rows
    logic [15:0] row_q;
    logic        row_ok;
    logic [RW-1:0] row_raddr;
    logic [27:0] ent_reg;
    logic        ent_ok_reg;
    assign row_ok = 32'(tgt_reg) < ROWS;
    assign row_raddr = RW'({list_q[19:11], list_q[10:8]});
    slc_ram #(.WIDTH(slc_pkg::ROW_W), .DEPTH(ROWS)) u_rows (
        .clk(clk), .we(cmd.row_we && row_ok), .waddr(tgt_reg[RW-1:0]),
        .wdata(wd_reg[15:0]), .raddr(row_raddr), .rdata(row_q));

    // pixel stage
    logic [7:0] dx;
    logic [2:0] bx;
    logic [1:0] idx;
    logic [2:0] monov;
    logic [8:0] addr;
    logic       hit;
    always_comb
    begin
        dx  = ent_reg[7:0] - pos_reg;
        bx  = dx[2:0] ^ {3{ent_reg[23]}};
        idx = row_q[{bx, 1'b0} +: 2];
        monov = mono_reg[{ent_reg[22], 3'b000} + {ent_reg[22], 2'b00}
                         + {idx, 1'b0} + 5'(idx) +: 3];
        if (!color_reg)
            addr = 9'(monov);
        else if (compat_reg)
            addr = cbase_reg + {5'd0, ent_reg[22], 3'd0} + 9'(monov);
        else
            addr = nbase_reg + {3'd0, ent_reg[27:24], 2'd0} + 9'(idx);
        hit = (dx < 8'd8) && ent_ok_reg && (idx != 2'd0);
    end

    logic       hit_reg;
    logic [1:0] prio_reg;
    logic [8:0] addr_reg;
    logic       ov_reg;
    logic [11:0] res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0; count_reg <= '0; ov_reg <= 1'b0; hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cache_start)
            begin
                walk_reg <= '0;
                hit_reg  <= 1'b0;
                if (slc_pkg::op_t'(op_reg) == slc_pkg::OP_CACHE)
                    count_reg <= '0;
            end
            else if (cmd.walk_inc)
                walk_reg <= walk_nx;
            if (cmd.attr_use && listed)
                count_reg <= count_reg + 1'b1;
            if (cmd.row_use)
                hit_reg <= hit;
            if (cmd.result_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cache_start)
        begin
            px_reg <= '0; py_reg <= '0;
        end
        else if (cmd.attr_use)
        begin
            px_reg <= sx; py_reg <= sy;
        end
        if (cmd.list_use)
        begin
            ent_reg    <= list_q;
            ent_ok_reg <= 32'(list_q[19:11]) < CHAR_COUNT;
        end
        if (cmd.row_use)
        begin
            prio_reg <= ent_reg[21:20];
            addr_reg <= addr;
        end
        if (cmd.result_load)
            out_data <= {4'd0, res_next};
    end

    assign res_next = hit_reg ? {addr_reg, prio_reg, 1'b1} : 12'd0;
    assign out_valid = ov_reg;

    always_comb
    begin
        stat.op             = op_reg;
        stat.walk_last_attr = 32'(walk_reg) == SPRITE_COUNT - 1;
        stat.walk_last_list = 32'(walk_reg) + 1 >= 32'(count_reg);
        stat.list_empty     = count_reg == '0;
        stat.hit            = hit_reg;
        stat.out_busy       = ov_reg && !out_ready;
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= SPRITE_COUNT) else $error("list overflow");
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> out_valid) else $error("result not shown");
    a_no_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data[0]) |-> out_data[11:1] == '0)
        else $error("stale payload");
endmodule

/* hw/rtl/sprite_line_cache_and_pixel.sv */
// Top level of the sprite line cache and pixel lookup.
// Depends on slc_pkg, slc_ctrl, slc_dp, slc_ram.
//
//  channel   direction  contents
//  s_axis    in         tdata: op[1:0] target_index[13:2] write_data[49:14] position[57:50]
//  m_axis    out        tdata: found[0] pixel_priority[2:1] color_address[11:3]
//  cfg       in         cfg_we, cfg_index (register 0..6), cfg_data
//
// Sprite/row writes pass through the dispatch state and return to idle. A
// cache-line walk reads all SPRITE_COUNT attribute entries through one RAM
// port. A render visits listed entries, each through the list read, char row
// read and evaluate states, stopping at the first opaque pixel.
// Reset clears control and config; tables are undefined until written.
// The result is held in the output register; while it waits, a render
// stalls in its final state.
`timescale 1ns / 1ps
module sprite_line_cache_and_pixel #(
    parameter int SPRITE_COUNT = slc_pkg::SPRITE_COUNT_DEF,
    parameter int CHAR_COUNT   = slc_pkg::CHAR_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // op, target_index, write_data, position
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // found, pixel_priority, color_address
    input  logic        cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data
);
    slc_pkg::slc_cmd_t  cmd;
    slc_pkg::slc_stat_t stat;
    logic [slc_pkg::TDATA_W-1:0] din;

    assign din = s_axis_tdata[57:0];

    slc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .stat(stat), .cmd(cmd));

    slc_dp #(.SPRITE_COUNT(SPRITE_COUNT), .CHAR_COUNT(CHAR_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_data(din),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata));
endmodule

/* test/sprite_line_cache_and_pixel_test.sv */
// Self-checking testbench for sprite_line_cache_and_pixel: directed table, then random
// traffic with stalls on both stream sides, checked against an in-bench sprite predictor.
// Depends on slc_pkg and the RTL of the block.
`timescale 1ns / 1ps
module sprite_line_cache_and_pixel_test;
    localparam int NSPR       = 64;
    localparam int NCHR       = 512;
    localparam int SETTLE     = 3 * NSPR + 60;  // worst walk plus margin
    localparam int NPHASE     = 6;
    localparam int PHASE_ITEMS = 140;

    typedef struct packed {
        logic       found;
        logic [1:0] prio;
        logic [8:0] addr;
    } pix_res_t;

    typedef struct packed {
        logic [7:0] x;
        logic [2:0] row;
        logic [8:0] chr;
        logic [1:0] prio;
        logic       pal;
        logic       hflip;
        logic [3:0] code;
    } line_ent_t;

    // one directed transaction; chk set where the result is typed in
    typedef struct packed {
        slc_pkg::op_t op;
        logic [11:0] target;
        logic [35:0] data;
        logic [7:0]  pos;
        logic        chk;
        pix_res_t    res;
    } dir_row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // op[1:0] target[13:2] data[49:14] position[57:50]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;        // found[0] priority[2:1] color_address[11:3]
    logic        cfg_we = 0;
    logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [slc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    sprite_line_cache_and_pixel uut (.*);

    always #4 clk = ~clk;

    // ---------------- predictor state ----------------
    logic        m_color, m_compat;
    logic [7:0]  m_scx, m_scy;
    logic [8:0]  m_cbase, m_nbase;
    logic [23:0] m_mono;
    logic [35:0] spr_attr [NSPR];
    logic [15:0] char_row [NCHR*8];
    line_ent_t   line_ent [NSPR];
    int          line_cnt;

    pix_res_t    pixel_q[$];      // expected render results, oldest first
    int          fail_cnt = 0;
    int          mism_cnt = 0;
    bit          calm = 0;        // no idling on either side while set

    // characters whose rows are all written; random sprites only reference these
    logic [8:0] chr_set [8] = '{9'd0, 9'd511, 9'd1, 9'd2, 9'd100, 9'd255, 9'd256, 9'd300};

    function automatic logic [35:0] mk_attr(logic [7:0] hoff, logic [7:0] voff, logic hch,
                                            logic vch, logic [1:0] prio, logic [8:0] chr,
                                            logic pal, logic hf, logic vf, logic [3:0] code);
        return {code, vf, hf, pal, chr, prio, vch, hch, voff, hoff};
    endfunction

    function automatic logic [2:0] mono_val(logic pal, logic [1:0] idx);
        return m_mono[12*pal + 3*idx +: 3];
    endfunction

    function automatic void build_line(logic [7:0] line);
        logic [7:0] px, py, sx, sy, y;
        logic [35:0] a;
        px = 0;
        py = 0;
        line_cnt = 0;
        for (int s = 0; s < NSPR; s++) begin
            a = spr_attr[s];
            sx = a[7:0];
            sy = a[15:8];
            if (a[16]) sx = sx + px;
            if (a[17]) sy = sy + py;
            px = sx;
            py = sy;
            if (a[19:18] == 0) continue;
            y = sy + m_scy + 8'd7 - line;
            if (y >= 8) continue;
            if (!a[31]) y = y ^ 8'd7;
            line_ent[line_cnt] = '{x: sx + m_scx + 8'd7, row: y[2:0], chr: a[28:20],
                                   prio: a[19:18], pal: a[29], hflip: a[30], code: a[35:32]};
            line_cnt++;
        end
    endfunction

    function automatic pix_res_t lookup_pixel(logic [7:0] col);
        pix_res_t r;
        logic [7:0] x;
        logic [1:0] idx;
        logic [8:0] addr;
        line_ent_t  t;
        r = '0;
        for (int i = 0; i < line_cnt; i++) begin
            t = line_ent[i];
            x = t.x - col;
            if (x >= 8) continue;
            if (t.hflip) x = x ^ 8'd7;
            idx = char_row[{t.chr, t.row}][2*x +: 2];
            if (idx == 0) continue;
            if (!m_color)
                addr = 9'(mono_val(t.pal, idx));
            else if (m_compat)
                addr = m_cbase + 9'(t.pal) * 9'd8 + 9'(mono_val(t.pal, idx));
            else
                addr = m_nbase + 9'(t.code) * 9'd4 + 9'(idx);
            r = '{found: 1'b1, prio: t.prio, addr: addr};
            return r;
        end
        return r;
    endfunction

    // apply one accepted transaction to the model
    function automatic void predict(slc_pkg::op_t op, logic [11:0] tgt, logic [35:0] d,
                                    logic [7:0] pos);
        case (op)
            slc_pkg::OP_SPRITE: if (tgt < NSPR) spr_attr[tgt] = d;
            slc_pkg::OP_ROW:    char_row[tgt] = d[15:0];
            slc_pkg::OP_CACHE:  build_line(pos);
            slc_pkg::OP_RENDER: pixel_q.push_back(lookup_pixel(pos));
            default: ;
        endcase
    endfunction

    // ---------------- drivers ----------------
    task automatic send(slc_pkg::op_t op, logic [11:0] tgt, logic [35:0] d, logic [7:0] pos);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, pos, d, tgt, op};
        do @(posedge clk); while (!s_axis_tready);
        predict(op, tgt, d, pos);
        @(negedge clk);
    endtask

    task automatic send_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(slc_pkg::reg_idx_t idx, logic [23:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            slc_pkg::REG_COLOR_MODEL: m_color  = v[0];
            slc_pkg::REG_COMPAT_MODE: m_compat = v[0];
            slc_pkg::REG_SCROLL_X:    m_scx    = v[7:0];
            slc_pkg::REG_SCROLL_Y:    m_scy    = v[7:0];
            slc_pkg::REG_COMPAT_BASE: m_cbase  = v[8:0];
            slc_pkg::REG_NATIVE_BASE: m_nbase  = v[8:0];
            slc_pkg::REG_MONO_PAL:    m_mono   = v;
            default: ;
        endcase
    endtask

    // block is idle once nothing is owed and a full walk has had time to finish
    task automatic drain();
        while (pixel_q.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ---------------- result side ----------------
    initial begin : sink
        int stall;
        pix_res_t got, want;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = '{found: m_axis_tdata[0], prio: m_axis_tdata[2:1], addr: m_axis_tdata[11:3]};
            if (pixel_q.size() == 0) begin
                fail_cnt++;
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("unexpected result transaction %h", m_axis_tdata[11:0]);
            end else begin
                want = pixel_q.pop_front();
                if (got != want) begin
                    fail_cnt++;
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("mismatch: exp found=%0d prio=%0d addr=%0d, got %0d %0d %0d",
                                 want.found, want.prio, want.addr,
                                 got.found, got.prio, got.addr);
                end
            end
            @(negedge clk);
        end
    end

    // ---------------- stimulus ----------------
    dir_row_t dir_tab [] = '{
        // nothing listed yet after reset: no sprite can be found
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd0,   1'b1, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd255, 1'b1, '0},
        // plain sprite at (10,20), then a chained one that lands at (4,22), both flips
        '{slc_pkg::OP_SPRITE, 12'd0, 36'h0_0030_140A, 8'd0, 1'b0, '0},
        '{slc_pkg::OP_SPRITE, 12'd1, 36'hF_FFE3_02FA, 8'd0, 1'b0, '0},
        // priority zero: never listed
        '{slc_pkg::OP_SPRITE, 12'd2, 36'h0_0000_140A, 8'd0, 1'b0, '0},
        // out of range sprite numbers are dropped
        '{slc_pkg::OP_SPRITE, 12'd64,   36'hF_FFFF_FFFF, 8'd0, 1'b0, '0},
        '{slc_pkg::OP_SPRITE, 12'd4095, 36'hF_FFFF_FFFF, 8'd0, 1'b0, '0},
        // row writes; bits above 15 are ignored
        '{slc_pkg::OP_ROW, 12'd0,    36'hF_FFFF_FFFF, 8'd0, 1'b0, '0},
        '{slc_pkg::OP_ROW, 12'd4095, 36'hA_AAAA_1B1B, 8'd0, 1'b0, '0},
        '{slc_pkg::OP_ROW, 12'd4088, 36'h0_0000_E4E4, 8'd0, 1'b0, '0},
        '{slc_pkg::OP_CACHE,  12'd0, 36'd0, 8'd27, 1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd17, 1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd10, 1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd9,  1'b0, '0},
        '{slc_pkg::OP_CACHE,  12'd0, 36'd0, 8'd29, 1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd11, 1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd4,  1'b0, '0},
        '{slc_pkg::OP_CACHE,  12'd0, 36'd0, 8'd0,  1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd0,  1'b0, '0},
        '{slc_pkg::OP_CACHE,  12'd0, 36'd0, 8'd255, 1'b0, '0},
        '{slc_pkg::OP_RENDER, 12'd0, 36'd0, 8'd255, 1'b0, '0}
    };

    function automatic logic [35:0] rand_attr();
        logic [7:0] hoff, voff;
        hoff = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 40));
        voff = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 40));
        return mk_attr(hoff, voff, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                       2'($urandom), chr_set[$urandom_range(0, 7)], 1'($urandom),
                       1'($urandom), 1'($urandom), 4'($urandom));
    endfunction

    task automatic rand_item();
        int k;
        int s;
        logic [7:0] line;
        k = $urandom_range(0, 99);
        if (k < 12) begin
            if ($urandom_range(0, 9) == 0)
                send(slc_pkg::OP_SPRITE, 12'($urandom_range(NSPR, 4095)),
                     36'({$urandom, $urandom}), 8'd0);
            else
                send(slc_pkg::OP_SPRITE, 12'($urandom_range(0, NSPR - 1)), rand_attr(),
                     8'($urandom));
        end else if (k < 22) begin
            if ($urandom_range(0, 1))
                send(slc_pkg::OP_ROW, {chr_set[$urandom_range(0, 7)], 3'($urandom)},
                     36'({$urandom, $urandom}), 8'($urandom));
            else
                send(slc_pkg::OP_ROW, 12'($urandom), 36'({$urandom, $urandom}),
                     8'($urandom));
        end else if (k < 38) begin
            // aim the line at some sprite most of the time
            s = $urandom_range(0, NSPR - 1);
            if ($urandom_range(0, 3) != 0)
                line = spr_attr[s][15:8] + m_scy + 8'd7 - 8'($urandom_range(0, 7));
            else
                line = 8'($urandom);
            send(slc_pkg::OP_CACHE, 12'($urandom), 36'({$urandom, $urandom}), line);
        end else begin
            if (line_cnt > 0 && $urandom_range(0, 4) != 0)
                line = line_ent[$urandom_range(0, line_cnt - 1)].x - 8'($urandom_range(0, 7));
            else
                line = 8'($urandom);
            send(slc_pkg::OP_RENDER, 12'($urandom), 36'({$urandom, $urandom}), line);
        end
    endtask

    initial begin : stim
        m_color = 0; m_compat = 0; m_scx = 0; m_scy = 0;
        m_cbase = 0; m_nbase = 0; m_mono = 0;
        line_cnt = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every sprite and every row of the used characters is filled first,
        // since a line walk reads all sprite entries
        for (int i = 0; i < NSPR; i++)
            send(slc_pkg::OP_SPRITE, 12'(i), rand_attr(), 8'd0);
        for (int c = 0; c < 8; c++)
            for (int r = 0; r < 8; r++)
                send(slc_pkg::OP_ROW, {chr_set[c], 3'(r)},
                     (r == 0) ? 36'd0 : (r == 7) ? 36'hF_FFFF_FFFF : 36'({$urandom, $urandom}),
                     8'd0);

        foreach (dir_tab[i]) begin
            send(dir_tab[i].op, dir_tab[i].target, dir_tab[i].data, dir_tab[i].pos);
            // typed rows are checked against the table as well as the predictor
            if (dir_tab[i].chk && pixel_q[$] != dir_tab[i].res) begin
                fail_cnt++;
                $display("directed row %0d: predictor disagrees with table", i);
            end
        end

        for (int ph = 0; ph < NPHASE; ph++) begin
            send_idle();
            drain();
            // first phase all maximum, last all minimum but a random mono palette, others random
            write_reg(slc_pkg::REG_COLOR_MODEL,
                      (ph == 0) ? 24'd1 : (ph == NPHASE-1) ? 24'd0 : 24'($urandom));
            write_reg(slc_pkg::REG_COMPAT_MODE,
                      (ph == 0) ? 24'd1 : (ph == NPHASE-1) ? 24'd0 : 24'($urandom));
            write_reg(slc_pkg::REG_SCROLL_X,
                      (ph == 0) ? 24'd255 : (ph == NPHASE-1) ? 24'd0 : 24'($urandom));
            write_reg(slc_pkg::REG_SCROLL_Y,
                      (ph == 0) ? 24'd255 : (ph == NPHASE-1) ? 24'd0 : 24'($urandom));
            write_reg(slc_pkg::REG_COMPAT_BASE,
                      (ph == 0) ? 24'd511 : (ph == NPHASE-1) ? 24'd0 : 24'($urandom));
            write_reg(slc_pkg::REG_NATIVE_BASE,
                      (ph == 0) ? 24'd511 : (ph == NPHASE-1) ? 24'd0 : 24'($urandom));
            write_reg(slc_pkg::REG_MONO_PAL, (ph == 0) ? 24'hFFFFFF : 24'($urandom));
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                rand_item();
        end
        send_idle();
        calm = 0;
        while (pixel_q.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
